>>> design/frd_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared types, register codes and constants of the dielectric Fresnel
// reflectance pipeline.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam int DIV_STEPS   = 29;
   localparam int SQRT_STEPS  = 15;
   localparam int RATIO_STEPS = 16;

   typedef enum logic {
      CSR_ETA_OUTSIDE = 1'b0,
      CSR_ETA_INSIDE  = 1'b1
   } csr_index_type;

   localparam logic [15:0] ETA_OUTSIDE_RESET = 16'd4096;
   localparam logic [15:0] ETA_INSIDE_RESET  = 16'd6144;
   localparam logic [15:0] ONE_Q15           = 16'd32768;
   localparam logic [14:0] COS_ONE           = 15'd16384;
   localparam logic [29:0] SQRT_FIRST_PROBE  = 30'h1000_0000;

   typedef struct packed {
      logic        tir;
      logic        degen;
      logic [14:0] cos_mag;
      logic [15:0] eta_i;
      logic [15:0] eta_t;
   } side_type;

   typedef struct packed {
      logic        valid;
      side_type    side;
      logic [31:0] rem;
      logic [31:0] divisor;
      logic [31:0] lo;
      logic [31:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic        valid;
      side_type    side;
      logic [29:0] rem;
      logic [29:0] root;
      logic [29:0] probe;
   } sqrt_lane_type;

endpackage

>>> design/frd_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring division cell
// Produces one quotient bit per item and hands the lane to the next cell.
// ----------------------------------------------------------------------------
module frd_div_cell import frd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_lane_type up_lane,
   output div_lane_type down_lane
);

   div_lane_type lane_ff;
   div_lane_type lane_in;
   logic [32:0]  trial;
   logic [32:0]  diff;

   always_comb begin
      trial   = {up_lane.rem, up_lane.lo[31]};
      diff    = trial - {1'b0, up_lane.divisor};
      lane_in = up_lane;
      lane_in.lo = {up_lane.lo[30:0], 1'b0};
      if (trial >= {1'b0, up_lane.divisor}) begin
         lane_in.rem = diff[31:0];
         lane_in.quo = {up_lane.quo[30:0], 1'b1};
      end else begin
         lane_in.rem = trial[31:0];
         lane_in.quo = {up_lane.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end
   end

   assign down_lane = lane_ff;

endmodule

>>> design/frd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Performs one digit step of the integer square root per item.
// ----------------------------------------------------------------------------
module frd_sqrt_cell import frd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sqrt_lane_type up_lane,
   output sqrt_lane_type down_lane
);

   sqrt_lane_type lane_ff;
   sqrt_lane_type lane_in;
   logic [30:0]   trial;

   always_comb begin
      trial   = {1'b0, up_lane.root} + {1'b0, up_lane.probe};
      lane_in = up_lane;
      lane_in.probe = {2'b00, up_lane.probe[29:2]};
      if ({1'b0, up_lane.rem} >= trial) begin
         lane_in.rem  = up_lane.rem - trial[29:0];
         lane_in.root = {1'b0, up_lane.root[29:1]} + up_lane.probe;
      end else begin
         lane_in.root = {1'b0, up_lane.root[29:1]};
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end
   end

   assign down_lane = lane_ff;

endmodule

>>> design/fresnel_dielectric_reflectance.sv
// ----------------------------------------------------------------------------
// Fresnel dielectric reflectance
// Unpolarized reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays low, so a
// new item may be started in every cycle. The item carries the incident
// cosine in signed Q2.14. The result appears on rsp_reflectance (Q1.15) and
// rsp_total_internal for exactly one cycle with rsp_valid high, in the order
// items were taken.
// Throughput is one item per cycle. The pipeline is a row of cells:
// 29 division cells for the transmitted cosine squared, 15 square root
// cells, and 16 cells with two division lanes for the amplitude ratios,
// plus nine stages for multiplies, sums and the output register.
// The two refractive indices are to be written through the csr_ port only
// while no item is in flight (not enforced); each write takes effect at once.
// Reset clears all valid flags and loads the default indices 1.0 and 1.5.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance import frd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_cos_incident,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wr_data,
   output logic               rsp_valid,
   output logic [15:0]        rsp_reflectance,
   output logic               rsp_total_internal
);

   logic [15:0]   eta_outside_ff;
   logic [15:0]   eta_inside_ff;
   logic          accept;

   logic [15:0]   raw;
   logic          entering;
   logic [15:0]   mag;
   logic [15:0]   eta_o;
   logic [15:0]   eta_n;
   side_type      a_side_in;
   side_type      a_side_ff;
   logic          a_valid_ff;

   logic [28:0]   b_c2_ff;
   logic [31:0]   b_ei2_ff;
   logic [31:0]   b_et2_ff;
   side_type      b_side_ff;
   logic          b_valid_ff;

   logic [28:0]   sin2;
   logic [60:0]   c_lhs_ff;
   logic [31:0]   c_et2_ff;
   side_type      c_side_ff;
   logic          c_valid_ff;

   logic [60:0]   rhs;
   logic [60:0]   dividend;
   div_lane_type  d_lane_in;
   div_lane_type  d_lane_ff;

   div_lane_type  div_lane [0:DIV_STEPS];
   sqrt_lane_type sqrt_lane [0:SQRT_STEPS];

   logic [14:0]   cos_t;
   logic [30:0]   p_a_ff;
   logic [30:0]   p_b_ff;
   logic [30:0]   p_cc_ff;
   logic [30:0]   p_d_ff;
   side_type      p_side_ff;
   logic          p_valid_ff;

   logic [31:0]   q_den_par_ff;
   logic [31:0]   q_den_perp_ff;
   logic [30:0]   q_num_par_ff;
   logic [30:0]   q_num_perp_ff;
   side_type      q_side_ff;
   logic          q_valid_ff;

   logic [47:0]   div_par;
   logic [47:0]   div_perp;
   div_lane_type  r_par_in;
   div_lane_type  r_perp_in;
   div_lane_type  r_par_ff;
   div_lane_type  r_perp_ff;

   div_lane_type  par_lane [0:RATIO_STEPS];
   div_lane_type  perp_lane [0:RATIO_STEPS];

   logic [31:0]   s_sq_par_ff;
   logic [31:0]   s_sq_perp_ff;
   side_type      s_side_ff;
   logic          s_valid_ff;

   logic [32:0]   sum;
   logic [15:0]   refl_in;
   logic          tir_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_outside_ff <= ETA_OUTSIDE_RESET;
         eta_inside_ff  <= ETA_INSIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ETA_OUTSIDE: eta_outside_ff <= csr_wr_data;
            CSR_ETA_INSIDE:  eta_inside_ff  <= csr_wr_data;
            default:         eta_outside_ff <= eta_outside_ff;
         endcase
      end
   end

   always_comb begin
      raw      = req_cos_incident;
      entering = !raw[15] && (raw != 16'd0);
      eta_o    = (eta_outside_ff == 16'd0) ? 16'd1 : eta_outside_ff;
      eta_n    = (eta_inside_ff == 16'd0) ? 16'd1 : eta_inside_ff;
      if (entering) begin
         mag = raw;
      end else if (raw[15]) begin
         mag = ~raw + 16'd1;
      end else begin
         mag = 16'd0;
      end
      a_side_in.tir     = 1'b0;
      a_side_in.degen   = 1'b0;
      a_side_in.cos_mag = (mag > {1'b0, COS_ONE}) ? COS_ONE : mag[14:0];
      a_side_in.eta_i   = entering ? eta_o : eta_n;
      a_side_in.eta_t   = entering ? eta_n : eta_o;
   end

   always_ff @(posedge clock) begin
      a_side_ff  <= a_side_in;
      b_c2_ff    <= 29'(a_side_ff.cos_mag * a_side_ff.cos_mag);
      b_ei2_ff   <= a_side_ff.eta_i * a_side_ff.eta_i;
      b_et2_ff   <= a_side_ff.eta_t * a_side_ff.eta_t;
      b_side_ff  <= a_side_ff;
      c_lhs_ff   <= 61'(b_ei2_ff * sin2);
      c_et2_ff   <= b_et2_ff;
      c_side_ff  <= b_side_ff;
      d_lane_ff  <= d_lane_in;
      if (reset) begin
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         d_lane_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   assign sin2 = 29'h1000_0000 - b_c2_ff;

   always_comb begin
      rhs      = {1'b0, c_et2_ff, 28'd0};
      dividend = rhs - c_lhs_ff;
      d_lane_in.valid    = c_valid_ff;
      d_lane_in.side     = c_side_ff;
      d_lane_in.side.tir = (c_lhs_ff >= rhs);
      d_lane_in.rem      = dividend[60:29];
      d_lane_in.lo       = {dividend[28:0], 3'b000};
      d_lane_in.divisor  = c_et2_ff;
      d_lane_in.quo      = 32'd0;
   end

   assign div_lane[0] = d_lane_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      frd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (div_lane[k]),
         .down_lane (div_lane[k+1])
      );
   end

   always_comb begin
      sqrt_lane[0].valid = div_lane[DIV_STEPS].valid;
      sqrt_lane[0].side  = div_lane[DIV_STEPS].side;
      sqrt_lane[0].rem   = {1'b0, div_lane[DIV_STEPS].quo[28:0]};
      sqrt_lane[0].root  = 30'd0;
      sqrt_lane[0].probe = SQRT_FIRST_PROBE;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      frd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (sqrt_lane[k]),
         .down_lane (sqrt_lane[k+1])
      );
   end

   assign cos_t = sqrt_lane[SQRT_STEPS].root[14:0];

   always_ff @(posedge clock) begin
      p_a_ff    <= sqrt_lane[SQRT_STEPS].side.eta_t * sqrt_lane[SQRT_STEPS].side.cos_mag;
      p_b_ff    <= sqrt_lane[SQRT_STEPS].side.eta_i * cos_t;
      p_cc_ff   <= sqrt_lane[SQRT_STEPS].side.eta_i * sqrt_lane[SQRT_STEPS].side.cos_mag;
      p_d_ff    <= sqrt_lane[SQRT_STEPS].side.eta_t * cos_t;
      p_side_ff <= sqrt_lane[SQRT_STEPS].side;

      q_den_par_ff  <= {1'b0, p_a_ff} + {1'b0, p_b_ff};
      q_den_perp_ff <= {1'b0, p_cc_ff} + {1'b0, p_d_ff};
      q_num_par_ff  <= (p_a_ff >= p_b_ff) ? (p_a_ff - p_b_ff) : (p_b_ff - p_a_ff);
      q_num_perp_ff <= (p_cc_ff >= p_d_ff) ? (p_cc_ff - p_d_ff) : (p_d_ff - p_cc_ff);
      q_side_ff     <= p_side_ff;

      r_par_ff  <= r_par_in;
      r_perp_ff <= r_perp_in;

      if (reset) begin
         p_valid_ff      <= 1'b0;
         q_valid_ff      <= 1'b0;
         r_par_ff.valid  <= 1'b0;
         r_perp_ff.valid <= 1'b0;
      end else begin
         p_valid_ff <= sqrt_lane[SQRT_STEPS].valid;
         q_valid_ff <= p_valid_ff;
      end
   end

   always_comb begin
      div_par  = {2'b00, q_num_par_ff, 15'd0} + {17'd0, q_den_par_ff[31:1]};
      div_perp = {2'b00, q_num_perp_ff, 15'd0} + {17'd0, q_den_perp_ff[31:1]};

      r_par_in.valid      = q_valid_ff;
      r_par_in.side       = q_side_ff;
      r_par_in.side.degen = (q_den_par_ff == 32'd0) || (q_den_perp_ff == 32'd0);
      r_par_in.rem        = div_par[47:16];
      r_par_in.lo         = {div_par[15:0], 16'd0};
      r_par_in.divisor    = q_den_par_ff;
      r_par_in.quo        = 32'd0;

      r_perp_in.valid     = q_valid_ff;
      r_perp_in.side      = q_side_ff;
      r_perp_in.rem       = div_perp[47:16];
      r_perp_in.lo        = {div_perp[15:0], 16'd0};
      r_perp_in.divisor   = q_den_perp_ff;
      r_perp_in.quo       = 32'd0;
   end

   assign par_lane[0]  = r_par_ff;
   assign perp_lane[0] = r_perp_ff;

   for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_ratio
      frd_div_cell u_par (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (par_lane[k]),
         .down_lane (par_lane[k+1])
      );
      frd_div_cell u_perp (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (perp_lane[k]),
         .down_lane (perp_lane[k+1])
      );
   end

   always_ff @(posedge clock) begin
      s_sq_par_ff  <= par_lane[RATIO_STEPS].quo[15:0] * par_lane[RATIO_STEPS].quo[15:0];
      s_sq_perp_ff <= perp_lane[RATIO_STEPS].quo[15:0] * perp_lane[RATIO_STEPS].quo[15:0];
      s_side_ff    <= par_lane[RATIO_STEPS].side;
      rsp_reflectance    <= refl_in;
      rsp_total_internal <= tir_in;
      if (reset) begin
         s_valid_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         s_valid_ff <= par_lane[RATIO_STEPS].valid;
         rsp_valid  <= s_valid_ff;
      end
   end

   always_comb begin
      sum    = {1'b0, s_sq_par_ff} + {1'b0, s_sq_perp_ff} + 33'h0_0000_8000;
      tir_in = s_side_ff.tir;
      if (s_side_ff.tir || s_side_ff.degen) begin
         refl_in = ONE_Q15;
      end else if (sum[32:16] > {1'b0, ONE_Q15}) begin
         refl_in = ONE_Q15;
      end else begin
         refl_in = sum[31:16];
      end
   end

`ifndef NO_ASSERTIONS
   a_refl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= ONE_Q15)
      else $error("Reflectance above one.");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == ONE_Q15)
      else $error("Total internal reflection without full reflectance.");

   a_cos_t_range: assert property (@(posedge clock) disable iff (reset)
      sqrt_lane[SQRT_STEPS].valid && !sqrt_lane[SQRT_STEPS].side.tir
      |-> sqrt_lane[SQRT_STEPS].root <= {15'd0, COS_ONE})
      else $error("Transmitted cosine above one.");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      par_lane[RATIO_STEPS].valid && !par_lane[RATIO_STEPS].side.tir
      && !par_lane[RATIO_STEPS].side.degen
      |-> par_lane[RATIO_STEPS].quo <= {16'd0, ONE_Q15}
          && perp_lane[RATIO_STEPS].quo <= {16'd0, ONE_Q15})
      else $error("Amplitude ratio above one.");
`endif

endmodule

>>> sim/tb_fresnel_dielectric_reflectance.sv
// ----------------------------------------------------------------------------
// Fresnel dielectric reflectance testbench
// Drives incident cosines through the reflectance pipeline under several
// index settings and compares every result with a local integer predictor.
// A directed table and an equal-index check run first, then random items in bursts.
// ----------------------------------------------------------------------------
module tb_fresnel_dielectric_reflectance;
   import frd_pkg::*;

   localparam int LATENCY   = 69;
   localparam int WATCHDOG  = 2000;
   localparam int N_RANDOM  = 1500;

   typedef struct packed {
      logic [15:0] reflectance;
      logic        total_internal;
   } fresnel_result_type;

   typedef struct {
      logic [15:0]        cos_val;
      logic               check_fixed;
      fresnel_result_type fixed;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_cos_incident = '0;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [15:0]        csr_wr_data = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_reflectance;
   logic               rsp_total_internal;

   logic [15:0]        eta_out_q = ETA_OUTSIDE_RESET;
   logic [15:0]        eta_in_q  = ETA_INSIDE_RESET;
   fresnel_result_type expected_reflectances[$];
   int                 error_count = 0;
   int                 result_count = 0;
   int                 item_count = 0;
   int                 tir_count = 0;
   int                 idle_cycles = 0;
   bit                 no_gaps = 1'b0;

   fresnel_dielectric_reflectance dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] amplitude_q15(logic [63:0] p, logic [63:0] q);
      logic [63:0] den;
      logic [63:0] num;
      den = p + q;
      num = (p >= q) ? p - q : q - p;
      return ((num << 15) + (den >> 1)) / den;
   endfunction

   function automatic fresnel_result_type predict_reflectance(logic [15:0] raw);
      fresnel_result_type res;
      logic [63:0] ei, et, tmp, c, sin2i, lhs, rhs, cos2t, cost;
      logic [63:0] a, b, cc, d, mpar, mperp, r;
      ei = (eta_out_q != 0) ? eta_out_q : 1;
      et = (eta_in_q != 0) ? eta_in_q : 1;
      if (raw != 0 && !raw[15]) begin
         c = raw;
      end else begin
         tmp = ei;
         ei = et;
         et = tmp;
         c = raw[15] ? 64'h10000 - raw : 0;
      end
      if (c > 16384) c = 16384;
      sin2i = (64'd1 << 28) - c * c;
      lhs = ei * ei * sin2i;
      rhs = (et * et) << 28;
      res.total_internal = 1'b0;
      res.reflectance = ONE_Q15;
      if (lhs >= rhs) begin
         res.total_internal = 1'b1;
         return res;
      end
      cos2t = (rhs - lhs) / (et * et);
      cost = int_sqrt(cos2t);
      a = et * c;
      b = ei * cost;
      cc = ei * c;
      d = et * cost;
      if (a + b == 0 || cc + d == 0) return res;
      mpar = amplitude_q15(a, b);
      mperp = amplitude_q15(cc, d);
      r = (mpar * mpar + mperp * mperp + (64'd1 << 15)) >> 16;
      if (r > 32768) r = 32768;
      res.reflectance = r[15:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH result %0d: %s got %0d expected %0d", result_count, what, got,
               want);
      error_count++;
   endtask

   always @(posedge clock) begin
      fresnel_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_reflectances.size() == 0) begin
            report_mismatch("unexpected result, reflectance", rsp_reflectance, 0);
         end else begin
            want = expected_reflectances.pop_front();
            if (rsp_reflectance !== want.reflectance)
               report_mismatch("reflectance", rsp_reflectance, want.reflectance);
            if (rsp_total_internal !== want.total_internal)
               report_mismatch("total_internal", rsp_total_internal, want.total_internal);
            if (want.total_internal) tir_count++;
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired with %0d results outstanding.",
                     expected_reflectances.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_index_reg(csr_index_type idx, logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ETA_OUTSIDE) eta_out_q = value;
      else eta_in_q = value;
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      while (expected_reflectances.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Drives one item; the expectation is queued when the item is accepted.
   task automatic send_cosine(logic [15:0] cos_val, bit check_fixed,
                              fresnel_result_type fixed);
      fresnel_result_type want;
      int gap;
      if (!no_gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      want = predict_reflectance(cos_val);
      if (check_fixed && want != fixed)
         report_mismatch("table entry", fixed.reflectance, want.reflectance);
      start <= 1'b1;
      req_cos_incident <= cos_val;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_reflectances.push_back(want);
      item_count++;
   endtask

   task automatic end_burst();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_cosine();
      case ($urandom_range(0, 5))
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 200));
         2: return 16'(32'h0001_0000 - $urandom_range(0, 200));
         3: return 16'(32'd16384 - $urandom_range(0, 300));
         default: return 16'($urandom_range(0, 32768) - 32'd16384);
      endcase
   endfunction

   initial begin
      stim_row_type table_rows[$];
      logic [15:0] eta_sets[8][2];
      fresnel_result_type tir_one;
      fresnel_result_type none;
      tir_one.reflectance = ONE_Q15;
      tir_one.total_internal = 1'b1;
      none = '0;
      eta_sets = '{'{16'd4096, 16'd6144}, '{16'd1, 16'd65535}, '{16'd65535, 16'd1},
                   '{16'd0, 16'd0}, '{16'd4096, 16'd4096}, '{16'd6144, 16'd4096},
                   '{16'd65535, 16'd65535}, '{16'd5000, 16'd9800}};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default indices, entering and leaving: normal, grazing and out-of-range cosines.
      table_rows.push_back('{16'd16384, 1'b0, none});
      table_rows.push_back('{16'd1, 1'b0, none});
      table_rows.push_back('{16'd0, 1'b1, tir_one});
      table_rows.push_back('{16'hC000, 1'b0, none});
      table_rows.push_back('{16'h8000, 1'b0, none});
      table_rows.push_back('{16'h7FFF, 1'b0, none});
      table_rows.push_back('{16'hFFFF, 1'b1, tir_one});
      table_rows.push_back('{16'd8192, 1'b0, none});
      table_rows.push_back('{16'hE000, 1'b0, none});
      table_rows.push_back('{16'hD000, 1'b0, none});
      table_rows.push_back('{16'h5555, 1'b0, none});
      table_rows.push_back('{16'hAAAA, 1'b0, none});
      foreach (table_rows[i])
         send_cosine(table_rows[i].cos_val, table_rows[i].check_fixed, table_rows[i].fixed);
      end_burst();
      drain_pipeline();

      // Equal indices: no reflection at all, except at grazing incidence.
      write_index_reg(CSR_ETA_OUTSIDE, 16'd4096);
      write_index_reg(CSR_ETA_INSIDE, 16'd4096);
      send_cosine(16'd16384, 1'b1, '{16'd0, 1'b0});
      send_cosine(16'hC000, 1'b1, '{16'd0, 1'b0});
      send_cosine(16'd0, 1'b1, '{ONE_Q15, 1'b1});
      end_burst();
      drain_pipeline();

      for (int s = 0; s < 8; s++) begin
         write_index_reg(CSR_ETA_OUTSIDE, eta_sets[s][0]);
         write_index_reg(CSR_ETA_INSIDE, eta_sets[s][1]);
         for (int k = 0; k < N_RANDOM / 10; k++) send_cosine(random_cosine(), 1'b0, none);
         end_burst();
         drain_pipeline();
      end

      write_index_reg(CSR_ETA_OUTSIDE, 16'($urandom_range(1, 20000)));
      write_index_reg(CSR_ETA_INSIDE, 16'($urandom_range(1, 20000)));
      for (int k = 0; k < N_RANDOM / 5; k++) begin
         if (k == N_RANDOM / 10) no_gaps = 1'b1;
         send_cosine(random_cosine(), 1'b0, none);
      end
      end_burst();
      drain_pipeline();

      $display("Sent %0d items over eleven index settings; %0d results checked,",
               item_count, result_count);
      $display("%0d of them total internal reflection.", tir_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
design/frd_pkg.sv
design/frd_div_cell.sv
design/frd_sqrt_cell.sv
design/fresnel_dielectric_reflectance.sv
sim/tb_fresnel_dielectric_reflectance.sv
